FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/cenum_pkg.sv
// Shared constants, types and command/status structs of the combination enumerator.
package cenum_pkg;

    localparam int MAX_COMPONENTS = 8;
    localparam int MAX_GENS       = 16;

    localparam int COMP_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int IDX_W   = $clog2(MAX_GENS);
    localparam int CNT_W   = $clog2(MAX_GENS + 2);
    localparam int K_W     = $clog2(MAX_COMPONENTS + 1);
    localparam int ADDR_W  = COMP_W + IDX_W;
    localparam int DEPTH   = MAX_COMPONENTS * MAX_GENS;
    localparam int NIB_W   = 4;

    localparam int DEG_W   = 16;
    localparam int RES_W   = 7;
    localparam int DIM_W   = 16;
    localparam int SUM_W   = 19;
    localparam int VEC_W   = 32;
    localparam int NCOMP_W = 4;
    localparam int WORD_W  = DEG_W + RES_W + DIM_W;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_NEXT   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] REG_NUM_COMPONENTS = 2'd0;
    localparam logic [1:0] REG_SAME_MASK      = 2'd1;
    localparam logic [1:0] REG_MAX_RESOLUTION = 2'd2;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_APPEND,
        KIND_CLEAR,
        KIND_COMB
    } kind_t;

    typedef enum logic [2:0] {
        P_HOLD,
        P_ZERO,
        P_TOP,
        P_INC,
        P_DEC
    } p_op_t;

    typedef struct packed {
        logic    latch;
        logic    first_step;
        logic    inc;
        logic    up;
        logic    fail;
        logic    fetch_start;
        logic    fetch_step;
        logic    out_load;
        p_op_t   p_op;
        kind_t   kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       any_empty;
        logic       p_top;
        logic       p_zero;
        logic       past;
        logic       up_ok;
        logic       in_range;
        logic       fetch_done;
        logic       dup;
        logic       out_free;
    } status_t;

endpackage

FILE: src/cenum_ctrl.sv
// Controller state machine of the combination enumerator.
module cenum_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cenum_pkg::status_t  st,
    output cenum_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FIRST    = 3'd2;
    localparam logic [2:0] S_INC      = 3'd3;
    localparam logic [2:0] S_UP       = 3'd4;
    localparam logic [2:0] S_CHECK    = 3'd5;
    localparam logic [2:0] S_FETCH    = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]       state_reg, state_next;
    cenum_pkg::kind_t kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cmd             = '0;
        cmd.p_op        = cenum_pkg::P_HOLD;
        cmd.kind        = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.mode == cenum_pkg::MODE_APPEND)
                begin
                    kind_next  = cenum_pkg::KIND_APPEND;
                    state_next = S_EMIT;
                end
                else if (st.mode == cenum_pkg::MODE_CLEAR)
                begin
                    kind_next  = cenum_pkg::KIND_CLEAR;
                    state_next = S_EMIT;
                end
                else if (st.any_empty)
                begin
                    kind_next  = cenum_pkg::KIND_ZERO;
                    state_next = S_EMIT;
                end
                else if (st.mode == cenum_pkg::MODE_FIRST)
                begin
                    cmd.p_op   = cenum_pkg::P_ZERO;
                    state_next = S_FIRST;
                end
                else
                begin
                    cmd.p_op   = cenum_pkg::P_TOP;
                    state_next = S_INC;
                end
            end
            S_FIRST:
            begin
                cmd.first_step = 1'b1;
                if (st.p_top)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.p_op = cenum_pkg::P_INC;
                end
            end
            S_CHECK:
            begin
                if (st.in_range)
                begin
                    cmd.fetch_start = 1'b1;
                    state_next      = S_FETCH;
                end
                else
                begin
                    cmd.p_op   = cenum_pkg::P_TOP;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                cmd.inc = 1'b1;
                if (!st.past)
                begin
                    if (st.p_top)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.p_op   = cenum_pkg::P_INC;
                        state_next = S_UP;
                    end
                end
                else if (st.p_zero)
                begin
                    cmd.fail   = 1'b1;
                    kind_next  = cenum_pkg::KIND_ZERO;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.p_op = cenum_pkg::P_DEC;
                end
            end
            S_UP:
            begin
                cmd.up = 1'b1;
                if (st.up_ok)
                begin
                    if (st.p_top)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.p_op = cenum_pkg::P_INC;
                    end
                end
                else
                begin
                    cmd.p_op   = cenum_pkg::P_DEC;
                    state_next = S_INC;
                end
            end
            S_FETCH:
            begin
                cmd.fetch_step = 1'b1;
                if (st.fetch_done)
                begin
                    if (st.dup)
                    begin
                        cmd.p_op   = cenum_pkg::P_TOP;
                        state_next = S_INC;
                    end
                    else
                    begin
                        kind_next  = cenum_pkg::KIND_COMB;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= cenum_pkg::KIND_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

FILE: src/cenum_dp.sv
// Datapath of the combination enumerator: lists, index vector, table memory and result.
module cenum_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cenum_pkg::cmd_t                   cmd,
    output cenum_pkg::status_t                st,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [7:0]                        cfg_wdata,
    input  logic [1:0]                        in_mode,
    input  logic [2:0]                        in_component,
    input  logic [cenum_pkg::DEG_W-1:0]       in_degree,
    input  logic [cenum_pkg::RES_W-1:0]       in_resolution,
    input  logic [cenum_pkg::DIM_W-1:0]       in_dim_limit,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_found,
    output logic                              out_overflow,
    output logic [cenum_pkg::VEC_W-1:0]       out_vector,
    output logic [cenum_pkg::SUM_W-1:0]       out_degree,
    output logic [cenum_pkg::DIM_W-1:0]       out_dim_limit,
    output logic [cenum_pkg::RES_W-1:0]       out_resolution
);

    localparam int NC = cenum_pkg::MAX_COMPONENTS;
    localparam int CW = cenum_pkg::CNT_W;
    localparam int PW = cenum_pkg::COMP_W;

    logic [cenum_pkg::NCOMP_W-1:0] ncomp_reg;
    logic [7:0]                    same_reg;
    logic [cenum_pkg::RES_W-1:0]   maxres_reg;

    logic [1:0]                    mode_reg;
    logic [2:0]                    comp_reg;
    logic [cenum_pkg::DEG_W-1:0]   deg_reg;
    logic [cenum_pkg::RES_W-1:0]   res_reg;
    logic [cenum_pkg::DIM_W-1:0]   dim_reg;

    logic [CW-1:0] cnt_reg [NC];
    logic [CW-1:0] cnt_next [NC];
    logic [CW-1:0] idx_reg [NC];
    logic [CW-1:0] idx_next [NC];
    logic [PW-1:0] p_reg, p_next, pm1;

    logic [cenum_pkg::WORD_W-1:0] mem [cenum_pkg::DEPTH];
    logic [cenum_pkg::WORD_W-1:0] rd_data_reg;
    logic [cenum_pkg::ADDR_W-1:0] rd_addr, wr_addr;

    logic [cenum_pkg::K_W-1:0]   k_reg;
    logic                        rv_reg;
    logic [PW-1:0]               rc_reg;
    logic [cenum_pkg::DEG_W-1:0] dcache_reg [NC];
    logic [cenum_pkg::SUM_W-1:0] sum_reg;
    logic [cenum_pkg::DIM_W-1:0] mdim_reg;
    logic [cenum_pkg::RES_W-1:0] mres_reg;
    logic                        dup_reg;

    logic [cenum_pkg::NCOMP_W-1:0] n_act;
    logic [CW-1:0]                 inc_val, fs_val, ups;
    logic [6:0]                    lhs, rhs;
    logic                          next_same, cur_same, appendable, issue;
    logic [cenum_pkg::DEG_W-1:0]   rd_deg;
    logic [cenum_pkg::RES_W-1:0]   rd_res;
    logic [cenum_pkg::DIM_W-1:0]   rd_dim;
    logic                          hit;
    logic [cenum_pkg::VEC_W-1:0]   vec;

    always_comb
    begin
        if (ncomp_reg == '0)
        begin
            n_act = cenum_pkg::NCOMP_W'(1);
        end
        else if (ncomp_reg > cenum_pkg::NCOMP_W'(NC))
        begin
            n_act = cenum_pkg::NCOMP_W'(NC);
        end
        else
        begin
            n_act = ncomp_reg;
        end
    end

    assign pm1       = p_reg - 1'b1;
    assign cur_same  = (p_reg != '0) && same_reg[p_reg];
    assign next_same = (({1'b0, p_reg} + 1'b1) < n_act) && same_reg[3'(p_reg + 1'b1)];

    // Past the end: beyond the list, or too far on for the following restart chain.
    assign inc_val = idx_reg[p_reg] + 1'b1;
    assign lhs     = 7'(inc_val) + 7'(n_act);
    assign rhs     = 7'(cnt_reg[p_reg]) + 7'(p_reg) + 7'd1;
    assign st.past = (inc_val >= cnt_reg[p_reg]) || (next_same && (lhs >= rhs));

    always_comb
    begin
        fs_val = cur_same ? CW'(idx_reg[pm1] + 1'b1) : '0;
        if (fs_val > cnt_reg[p_reg])
        begin
            fs_val = cnt_reg[p_reg];
        end
    end

    assign ups      = cur_same ? CW'(idx_reg[pm1] + 1'b1) : '0;
    assign st.up_ok = ups < cnt_reg[p_reg];

    assign st.mode   = mode_reg;
    assign st.p_top  = ({1'b0, p_reg} == 4'(n_act - 1'b1));
    assign st.p_zero = (p_reg == '0);

    always_comb
    begin
        st.any_empty = 1'b0;
        st.in_range  = 1'b1;
        for (int j = 0; j < NC; j++)
        begin
            if (cenum_pkg::NCOMP_W'(j) < n_act)
            begin
                if (cnt_reg[j] == '0)
                begin
                    st.any_empty = 1'b1;
                end
                if (idx_reg[j] >= cnt_reg[j])
                begin
                    st.in_range = 1'b0;
                end
            end
        end
    end

    assign appendable = ({1'b0, comp_reg} < 4'(NC)) &&
                        (cnt_reg[comp_reg[PW-1:0]] < CW'(cenum_pkg::MAX_GENS));

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.out_load && (cmd.kind == cenum_pkg::KIND_CLEAR))
        begin
            for (int j = 0; j < NC; j++)
            begin
                cnt_next[j] = '0;
                idx_next[j] = '0;
            end
        end
        else if (cmd.out_load && (cmd.kind == cenum_pkg::KIND_APPEND) && appendable)
        begin
            cnt_next[comp_reg[PW-1:0]] = cnt_reg[comp_reg[PW-1:0]] + 1'b1;
        end
        else if (cmd.first_step)
        begin
            idx_next[p_reg] = fs_val;
        end
        else if (cmd.fail)
        begin
            for (int j = 0; j < NC; j++)
            begin
                if (cenum_pkg::NCOMP_W'(j) < n_act)
                begin
                    idx_next[j] = cnt_reg[j];
                end
            end
        end
        else if (cmd.inc)
        begin
            idx_next[p_reg] = inc_val;
        end
        else if (cmd.up && st.up_ok)
        begin
            idx_next[p_reg] = ups;
        end
    end

    always_comb
    begin
        unique case (cmd.p_op)
            cenum_pkg::P_HOLD: p_next = p_reg;
            cenum_pkg::P_ZERO: p_next = '0;
            cenum_pkg::P_TOP:  p_next = PW'(n_act - 1'b1);
            cenum_pkg::P_INC:  p_next = p_reg + 1'b1;
            cenum_pkg::P_DEC:  p_next = pm1;
            default:           p_next = p_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncomp_reg  <= cenum_pkg::NCOMP_W'(1);
            same_reg   <= '0;
            maxres_reg <= cenum_pkg::RES_W'(32);
            p_reg      <= '0;
            for (int j = 0; j < NC; j++)
            begin
                cnt_reg[j] <= '0;
                idx_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    cenum_pkg::REG_NUM_COMPONENTS: ncomp_reg  <= cfg_wdata[3:0];
                    cenum_pkg::REG_SAME_MASK:      same_reg   <= cfg_wdata;
                    cenum_pkg::REG_MAX_RESOLUTION: maxres_reg <= cfg_wdata[6:0];
                    default:                       ;
                endcase
            end
            p_reg   <= p_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= in_mode;
            comp_reg <= in_component;
            deg_reg  <= in_degree;
            res_reg  <= in_resolution;
            dim_reg  <= in_dim_limit;
        end
    end

    // Table memory: one write port for appends, one registered read port for fetches.
    assign wr_addr = {comp_reg[PW-1:0], cnt_reg[comp_reg[PW-1:0]][cenum_pkg::IDX_W-1:0]};
    assign issue   = cmd.fetch_step && (k_reg < cenum_pkg::K_W'(n_act));
    assign rd_addr = {k_reg[PW-1:0], idx_reg[k_reg[PW-1:0]][cenum_pkg::IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load && (cmd.kind == cenum_pkg::KIND_APPEND) && appendable)
        begin
            mem[wr_addr] <= {dim_reg, res_reg, deg_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_deg = rd_data_reg[cenum_pkg::DEG_W-1:0];
    assign rd_res = rd_data_reg[cenum_pkg::DEG_W+cenum_pkg::RES_W-1:cenum_pkg::DEG_W];
    assign rd_dim = rd_data_reg[cenum_pkg::WORD_W-1:cenum_pkg::DEG_W+cenum_pkg::RES_W];

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < NC; i++)
        begin
            if ((PW'(i) < rc_reg) && (dcache_reg[i] == rd_deg))
            begin
                hit = 1'b1;
            end
        end
    end

    assign st.fetch_done = (k_reg == cenum_pkg::K_W'(n_act)) && !rv_reg;
    assign st.dup        = dup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            rv_reg <= 1'b0;
        end
        else if (cmd.fetch_start)
        begin
            k_reg  <= '0;
            rv_reg <= 1'b0;
        end
        else if (cmd.fetch_step)
        begin
            rv_reg <= issue;
            if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_start)
        begin
            sum_reg  <= '0;
            mdim_reg <= '1;
            mres_reg <= '1;
            dup_reg  <= 1'b0;
        end
        else if (cmd.fetch_step)
        begin
            rc_reg <= k_reg[PW-1:0];
            if (rv_reg)
            begin
                dcache_reg[rc_reg] <= rd_deg;
                sum_reg            <= sum_reg + cenum_pkg::SUM_W'(rd_deg);
                if (rd_dim < mdim_reg)
                begin
                    mdim_reg <= rd_dim;
                end
                if (rd_res < mres_reg)
                begin
                    mres_reg <= rd_res;
                end
                if (hit)
                begin
                    dup_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        vec = '0;
        for (int j = 0; j < NC; j++)
        begin
            if (cenum_pkg::NCOMP_W'(j) < n_act)
            begin
                vec[j*cenum_pkg::NIB_W +: cenum_pkg::NIB_W] = idx_reg[j][cenum_pkg::NIB_W-1:0];
            end
        end
    end

    assign st.out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found      <= 1'b0;
            out_overflow   <= 1'b0;
            out_vector     <= '0;
            out_degree     <= '0;
            out_dim_limit  <= '0;
            out_resolution <= '0;
            unique case (cmd.kind)
                cenum_pkg::KIND_APPEND:
                begin
                    out_found    <= appendable;
                    out_overflow <= !appendable;
                end
                cenum_pkg::KIND_COMB:
                begin
                    out_found      <= 1'b1;
                    out_vector     <= vec;
                    out_degree     <= sum_reg;
                    out_dim_limit  <= mdim_reg;
                    out_resolution <= (mres_reg > maxres_reg) ? maxres_reg : mres_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: src/combination_enumerator.sv
// Top level of the mixed-radix combination enumerator.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser mode, tdata generator
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser flags, tdata combination
// cfg       in         cfg_we                        cfg_addr, cfg_wdata
//
// One item is in work at a time. Append and clear go from dispatch straight to emit.
// First and next go from dispatch through the index steps of the carry sequencer; each
// candidate with all indices in range has every active entry read through the table
// memory read port, and one without duplicate degrees, or a failed search, is emitted.
// Reset clears lists and indices at once; table contents need no clearing.
// A stalled result waits in the output register and holds the controller.
module combination_enumerator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // mode
    input  logic [47:0]  s_axis_tdata,   // component, gen_degree, gen_resolution, gen_dim_limit
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [1:0]   m_axis_tuser,   // found, append_overflow
    output logic [79:0]  m_axis_tdata    // index_vector, total_degree, min_dim_limit, resolution
);

    cenum_pkg::cmd_t    cmd;
    cenum_pkg::status_t st;

    logic [cenum_pkg::VEC_W-1:0] vec;
    logic [cenum_pkg::SUM_W-1:0] deg;
    logic [cenum_pkg::DIM_W-1:0] dim;
    logic [cenum_pkg::RES_W-1:0] res;
    logic                        found, ovf;

    cenum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cenum_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_mode        (s_axis_tuser),
        .in_component   (s_axis_tdata[2:0]),
        .in_degree      (s_axis_tdata[18:3]),
        .in_resolution  (s_axis_tdata[25:19]),
        .in_dim_limit   (s_axis_tdata[41:26]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_found      (found),
        .out_overflow   (ovf),
        .out_vector     (vec),
        .out_degree     (deg),
        .out_dim_limit  (dim),
        .out_resolution (res)
    );

    assign m_axis_tuser = {ovf, found};
    assign m_axis_tdata = {6'd0, res, dim, deg, vec};

endmodule

FILE: src/cenum_checker.sv
// Port-level checker for the combination enumerator and its bind.
`include "assert_macros.svh"

module cenum_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [1:0]   m_axis_tuser,
    input logic [79:0]  m_axis_tdata
);

    `ASSERT_NEVER(a_flags_excl, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "found and overflow both set")
    `ASSERT_CLK(a_zero_payload, clk, rst_n, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 80'd0), "payload not zero without a combination")
    `ASSERT_CLK(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")

endmodule

bind combination_enumerator cenum_checker u_cenum_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/combination_enumerator_checker.sv
// Checker that predicts and compares every result transfer of the combination enumerator.
module combination_enumerator_checker
    import cenum_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [1:0]  m_axis_tuser,
    input  logic [79:0] m_axis_tdata,
    output int          fails,
    output int          outstanding
);

    typedef struct packed {
        logic        found;
        logic        overflow;
        logic [31:0] index_vec;
        logic [18:0] degree_sum;
        logic [15:0] dim_min;
        logic [6:0]  res_min;
    } combo_result_t;

    combo_result_t pending_results[$];

    logic [3:0]  comp_count_reg;
    logic [7:0]  same_reg;
    logic [6:0]  res_cap_reg;
    int          list_len[MAX_COMPONENTS];
    int          pick[MAX_COMPONENTS];
    logic [15:0] deg_table[DEPTH];
    logic [6:0]  res_table[DEPTH];
    logic [15:0] dim_table[DEPTH];

    function automatic bit restarts(int j);
        return j > 0 && same_reg[j];
    endfunction

    function automatic bit beyond_list(int j, int n);
        if (pick[j] >= list_len[j])
            return 1'b1;
        if (j + 1 < n && restarts(j + 1) && pick[j] >= list_len[j] - n + j + 1)
            return 1'b1;
        return 1'b0;
    endfunction

    // Carry sequencer: increments component top, propagating carries toward component 0.
    function automatic bit step_pick(int top, int n);
        int j;
        int start;
        bit ok;
        bit descend;
        j = top;
        descend = 1'b1;
        ok = 1'b0;
        forever begin
            if (descend) begin
                pick[j] = pick[j] + 1;
                if (!beyond_list(j, n)) begin
                    ok = 1'b1;
                    descend = 1'b0;
                end else if (j == 0) begin
                    pick[0] = list_len[0];
                    ok = 1'b0;
                    descend = 1'b0;
                end else begin
                    j = j - 1;
                    continue;
                end
            end
            if (j == top)
                return ok;
            j = j + 1;
            if (!ok) begin
                pick[j] = list_len[j];
            end else begin
                start = restarts(j) ? pick[j - 1] + 1 : 0;
                if (start < list_len[j]) begin
                    pick[j] = start;
                end else begin
                    j = j - 1;
                    descend = 1'b1;
                end
            end
        end
    endfunction

    function automatic bit distinct_degrees(int n);
        for (int a = 0; a < n; a++)
            if (pick[a] >= list_len[a])
                return 1'b0;
        for (int a = 0; a < n; a++)
            for (int b = a + 1; b < n; b++)
                if (deg_table[a * MAX_GENS + pick[a]] == deg_table[b * MAX_GENS + pick[b]])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic combo_result_t summarize(int n);
        combo_result_t r;
        int s;
        r = '0;
        r.found = 1'b1;
        r.dim_min = 16'hFFFF;
        r.res_min = 7'h7F;
        for (int j = 0; j < n; j++) begin
            s = j * MAX_GENS + pick[j];
            r.index_vec[4 * j +: 4] = pick[j][3:0];
            r.degree_sum = r.degree_sum + 19'(deg_table[s]);
            if (dim_table[s] < r.dim_min)
                r.dim_min = dim_table[s];
            if (res_table[s] < r.res_min)
                r.res_min = res_table[s];
        end
        if (r.res_min > res_cap_reg)
            r.res_min = res_cap_reg;
        return r;
    endfunction

    function automatic combo_result_t enumerate(logic [1:0] mode, logic [47:0] gen);
        combo_result_t r;
        int n;
        int c;
        int s;
        int start;
        r = '0;
        n = (comp_count_reg == 0) ? 1 :
            (comp_count_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(comp_count_reg);
        if (mode == MODE_APPEND) begin
            c = int'(gen[2:0]);
            if (list_len[c] >= MAX_GENS) begin
                r.overflow = 1'b1;
            end else begin
                s = c * MAX_GENS + list_len[c];
                deg_table[s] = gen[18:3];
                res_table[s] = gen[25:19];
                dim_table[s] = gen[41:26];
                list_len[c] = list_len[c] + 1;
                r.found = 1'b1;
            end
            return r;
        end
        if (mode == MODE_CLEAR) begin
            for (int j = 0; j < MAX_COMPONENTS; j++) begin
                list_len[j] = 0;
                pick[j] = 0;
            end
            return r;
        end
        for (int j = 0; j < n; j++)
            if (list_len[j] == 0)
                return r;
        if (mode == MODE_FIRST) begin
            for (int j = 0; j < n; j++) begin
                start = restarts(j) ? pick[j - 1] + 1 : 0;
                if (start > list_len[j])
                    start = list_len[j];
                pick[j] = start;
            end
            if (distinct_degrees(n))
                return summarize(n);
        end
        forever begin
            if (!step_pick(n - 1, n))
                return r;
            if (distinct_degrees(n))
                return summarize(n);
        end
    endfunction

    task automatic report_mismatch(string what, logic [79:0] got, logic [79:0] want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        fails++;
    endtask

    assign outstanding = pending_results.size();

    always @(posedge clk or negedge rst_n) begin
        combo_result_t want;
        if (!rst_n) begin
            comp_count_reg <= 4'd1;
            same_reg <= 8'd0;
            res_cap_reg <= 7'd32;
            for (int j = 0; j < MAX_COMPONENTS; j++) begin
                list_len[j] = 0;
                pick[j] = 0;
            end
            pending_results.delete();
            fails = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_NUM_COMPONENTS)
                    comp_count_reg <= cfg_wdata[3:0];
                else if (cfg_addr == REG_SAME_MASK)
                    same_reg <= cfg_wdata;
                else if (cfg_addr == REG_MAX_RESOLUTION)
                    res_cap_reg <= cfg_wdata[6:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(enumerate(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser[0] !== want.found)
                        report_mismatch("found", m_axis_tuser[0], want.found);
                    if (m_axis_tuser[1] !== want.overflow)
                        report_mismatch("append_overflow", m_axis_tuser[1], want.overflow);
                    if (m_axis_tdata[31:0] !== want.index_vec)
                        report_mismatch("index_vector", m_axis_tdata[31:0], want.index_vec);
                    if (m_axis_tdata[50:32] !== want.degree_sum)
                        report_mismatch("total_degree", m_axis_tdata[50:32], want.degree_sum);
                    if (m_axis_tdata[66:51] !== want.dim_min)
                        report_mismatch("min_dim_limit", m_axis_tdata[66:51], want.dim_min);
                    if (m_axis_tdata[73:67] !== want.res_min)
                        report_mismatch("resolution", m_axis_tdata[73:67], want.res_min);
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top that drives the combination enumerator and gives the verdict.
module tb;
    import cenum_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int SPACE_LIMIT = 256;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;
    logic [79:0] m_axis_tdata;
    int          fails;
    int          outstanding;

    bit          calm;
    bit          result_taken;
    int          ready_gap;
    int          quiet_cycles;
    int          sent;
    int          comp_active;
    int          fill[MAX_COMPONENTS];

    combination_enumerator dut (.*);

    combination_enumerator_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        result_taken = m_axis_tvalid && m_axis_tready;
        if ((s_axis_tvalid && s_axis_tready) || result_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL combination_enumerator");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (result_taken)
            ready_gap = calm ? 0 : $urandom_range(0, 6);
        m_axis_tready <= (ready_gap == 0);
        if (ready_gap > 0)
            ready_gap--;
    end

    task automatic send(logic [1:0] mode, logic [2:0] comp, logic [15:0] deg,
                        logic [6:0] res, logic [15:0] dim);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {6'b0, dim, res, deg, comp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent++;
        if (mode == MODE_APPEND && fill[comp] < MAX_GENS)
            fill[comp]++;
        if (mode == MODE_CLEAR)
            foreach (fill[j])
                fill[j] = 0;
    endtask

    task automatic add_gen(int comp, bit dup_heavy);
        logic [15:0] dim;
        dim = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
        send(MODE_APPEND, 3'(comp), dup_heavy ? 16'($urandom_range(0, 5)) : 16'($urandom),
             7'($urandom_range(0, 64)), dim);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_NUM_COMPONENTS)
            comp_active = (value[3:0] == 0) ? 1 :
                          (value[3:0] > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(value[3:0]);
    endtask

    function automatic int space_with(int comp);
        int prod;
        prod = 1;
        for (int j = 0; j < comp_active; j++)
            prod = prod * (fill[j] + ((j == comp) ? 1 : 0));
        return prod;
    endfunction

    initial
    begin
        int target;
        int steps;
        int comp;
        bit dup_heavy;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        calm = 1'b0;
        ready_gap = 0;
        quiet_cycles = 0;
        sent = 0;
        comp_active = 1;
        foreach (fill[j])
            fill[j] = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty lists, field extremes, overflow, exhaustion, clear.
        send(MODE_NEXT, 3'd0, 16'd0, 7'd0, 16'd0);
        send(MODE_FIRST, 3'd0, 16'd0, 7'd0, 16'd0);
        send(MODE_APPEND, 3'd0, 16'd0, 7'd0, 16'd0);
        send(MODE_APPEND, 3'd0, 16'hFFFF, 7'd64, 16'hFFFF);
        send(MODE_APPEND, 3'd0, 16'hFFFF, 7'd63, 16'h1234);
        send(MODE_FIRST, 3'd0, 16'd0, 7'd0, 16'd0);
        repeat (3) send(MODE_NEXT, 3'd0, 16'd0, 7'd0, 16'd0);
        repeat (17) send(MODE_APPEND, 3'd7, 16'hA5A5, 7'd64, 16'h5A5A);
        send(MODE_CLEAR, 3'd7, 16'hFFFF, 7'd127, 16'hFFFF);
        send(MODE_FIRST, 3'd0, 16'd0, 7'd0, 16'd0);

        while (sent < 800)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: target = 0;
                1: target = 15;
                2: target = MAX_COMPONENTS;
                default: target = $urandom_range(1, 4);
            endcase
            write_reg(REG_NUM_COMPONENTS, 8'(target));
            write_reg(REG_SAME_MASK, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
            case ($urandom_range(0, 4))
                0: write_reg(REG_MAX_RESOLUTION, 8'd1);
                1: write_reg(REG_MAX_RESOLUTION, 8'd64);
                default: write_reg(REG_MAX_RESOLUTION, 8'($urandom_range(1, 64)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            dup_heavy = ($urandom_range(0, 2) == 0);
            send(MODE_CLEAR, 3'($urandom), 16'($urandom), 7'($urandom), 16'($urandom));
            for (int j = 0; j < MAX_COMPONENTS; j++)
            begin
                if (j >= comp_active)
                    target = $urandom_range(0, 3);
                else if ($urandom_range(0, 19) == 0)
                    target = 0;
                else
                    target = $urandom_range(1, MAX_GENS);
                while (fill[j] < target && space_with(j) <= SPACE_LIMIT)
                    add_gen(j, dup_heavy);
            end
            send(MODE_FIRST, 3'($urandom), 16'($urandom), 7'($urandom), 16'($urandom));
            steps = $urandom_range(1, 40);
            for (int i = 0; i < steps; i++)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    send(MODE_NEXT, 3'($urandom), 16'($urandom), 7'($urandom), 16'($urandom));
                end
                else
                begin
                    comp = $urandom_range(0, MAX_COMPONENTS - 1);
                    case ($urandom_range(0, 3))
                        0: send(MODE_CLEAR, 3'($urandom), 16'($urandom), 7'($urandom),
                                16'($urandom));
                        1: send(MODE_FIRST, 3'($urandom), 16'($urandom), 7'($urandom),
                                16'($urandom));
                        default:
                            if (space_with(comp) <= SPACE_LIMIT || fill[comp] >= MAX_GENS)
                                add_gen(comp, dup_heavy);
                            else
                                send(MODE_NEXT, 3'd0, 16'd0, 7'd0, 16'd0);
                    endcase
                end
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (fails == 0 && outstanding == 0)
            $display("PASS combination_enumerator");
        else
            $display("FAIL combination_enumerator");
        $finish;
    end

endmodule
